@@ hdl/bie_pkg.sv @@
// Shared types and constants for the barycentric interpolation evaluator.
package bie_pkg;

    localparam int DivW   = 128;
    localparam int DivCntW = 8;

    localparam logic [DivCntW-1:0] U_STEPS   = 8'd64;
    localparam logic [DivCntW-1:0] T_STEPS   = 8'd62;
    localparam logic [DivCntW-1:0] FIN_STEPS = 8'd128;

    localparam logic [1:0] REG_DOMAIN_LOW  = 2'd0;
    localparam logic [1:0] REG_DOMAIN_HIGH = 2'd1;
    localparam logic [1:0] REG_NODE_COUNT  = 2'd2;

    localparam logic [31:0] DOMAIN_LOW_RST  = 32'hFFFF_0000;
    localparam logic [31:0] DOMAIN_HIGH_RST = 32'h0001_0000;
    localparam logic [6:0]  NODE_COUNT_RST  = 7'd2;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    localparam logic CMD_LOAD = 1'b0;

    typedef enum logic [1:0] {
        K_LOAD,
        K_SKIP,
        K_EVAL
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [5:0]         node_index;
        logic signed [31:0] node_point;
        logic signed [31:0] node_weight;
        logic signed [31:0] node_value;
        logic signed [31:0] query_x;
    } t_item;

    typedef struct packed {
        logic signed [31:0] domain_low;
        logic signed [31:0] domain_high;
        logic [6:0]         node_count;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_U_START,
        S_U_DIV,
        S_HIT_RD,
        S_HIT_CMP,
        S_SUM_RD,
        S_T_START,
        S_T_DIV,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_FIN_START,
        S_FIN_DIV,
        S_RESULT
    } t_state;

endpackage

@@ hdl/bie_front.sv @@
// Front end: accepts input beats, classifies them and queues them for the back end.
module bie_front #(
    parameter int MAX_NODES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [5:0]         i_node_index,
    input  logic signed [31:0] i_node_point,
    input  logic signed [31:0] i_node_weight,
    input  logic signed [31:0] i_node_value,
    input  logic signed [31:0] i_query_x,
    output logic               o_item_valid,
    output bie_pkg::t_item     o_item,
    input  logic               i_pop
);

    bie_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    bie_pkg::t_item item;

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_comb begin
        item.node_index  = i_node_index;
        item.node_point  = i_node_point;
        item.node_weight = i_node_weight;
        item.node_value  = i_node_value;
        item.query_x     = i_query_x;
        if (i_command != bie_pkg::CMD_LOAD) begin
            item.kind = bie_pkg::K_EVAL;
        end else if (int'(i_node_index) >= MAX_NODES) begin
            item.kind = bie_pkg::K_SKIP;
        end else begin
            item.kind = bie_pkg::K_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

@@ hdl/bie_div.sv @@
// Restoring serial divider, one quotient bit per cycle, dividend left-aligned by caller.
module bie_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [bie_pkg::DivW-1:0]          i_dividend,
    input  logic [bie_pkg::DivW-1:0]          i_divisor,
    input  logic [bie_pkg::DivCntW-1:0]       i_steps,
    output logic                              o_done,
    output logic [bie_pkg::DivW-1:0]          o_quotient
);

    logic [bie_pkg::DivW:0]          r_rem;
    logic [bie_pkg::DivW-1:0]        r_quo;
    logic [bie_pkg::DivW-1:0]        r_dvs;
    logic [bie_pkg::DivCntW-1:0]     r_cnt;
    logic                            r_busy, r_done;
    logic [bie_pkg::DivW:0]          rem_sh;
    logic                            fits;

    assign rem_sh     = {r_rem[bie_pkg::DivW-1:0], r_quo[bie_pkg::DivW-1]};
    assign fits       = (rem_sh >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_cnt <= i_steps;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sh - {1'b0, r_dvs} : rem_sh;
            r_quo <= {r_quo[bie_pkg::DivW-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 1);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/bie_back.sv @@
// Back end: node tables, evaluation sequencer, arithmetic and result register.
module bie_back #(
    parameter int MAX_NODES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bie_pkg::t_cfg      i_cfg,
    input  logic               i_item_valid,
    input  bie_pkg::t_item     i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_interp_value,
    output logic               o_exact_hit,
    output logic               o_status
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    localparam logic [31:0] SAT_POS_C = bie_pkg::SAT_POS;
    localparam logic [31:0] SAT_NEG_C = bie_pkg::SAT_NEG;

    bie_pkg::t_state r_state, n_state;

    logic [31:0] r_mem_point  [MAX_NODES];
    logic [31:0] r_mem_weight [MAX_NODES];
    logic [31:0] r_mem_value  [MAX_NODES];
    logic signed [31:0] r_rd_point, r_rd_weight, r_rd_value;

    logic signed [31:0]  r_x;
    logic signed [41:0]  r_u;
    logic [CW-1:0]       r_idx;
    logic [61:0]         r_t;
    logic                r_tneg;
    logic [63:0]         r_p0, r_p1;
    logic [127:0]        r_nsum, r_dsum;
    logic [31:0]         r_res_value;
    logic                r_res_hit, r_res_status;
    logic                r_out_valid;
    logic [31:0]         r_out_value;
    logic                r_out_hit, r_out_status;

    // control strobes
    logic mem_we, rd_en, div_start, out_load, out_free;
    logic [bie_pkg::DivW-1:0]    div_dvd, div_dvs, div_q;
    logic [bie_pkg::DivCntW-1:0] div_steps;
    logic                        div_done;

    // derived values
    logic [CW-1:0]       cnt;
    logic [AW+5:0]       wr_ext;
    logic signed [31:0]  dlo, dhi;
    logic signed [34:0]  unum;
    logic [33:0]         unum_mag;
    logic signed [32:0]  den;
    logic [40:0]         u_mag;
    logic signed [42:0]  diff;
    logic [42:0]         diff_mag;
    logic [31:0]         w_mag, v_mag;
    logic [31:0]         mul_a;
    logic [127:0]        prod;
    logic [127:0]        nmag, dmag;
    logic                fneg, fover, fsat;
    logic [31:0]         fq;
    logic                hit;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        if (int'(i_cfg.node_count) > MAX_NODES) begin
            cnt = CW'(MAX_NODES);
        end else begin
            cnt = CW'(i_cfg.node_count);
        end
        wr_ext = (AW + 6)'(i_item.node_index);
        if (i_cfg.domain_low > i_cfg.domain_high) begin
            dlo = i_cfg.domain_high;
            dhi = i_cfg.domain_low;
        end else begin
            dlo = i_cfg.domain_low;
            dhi = i_cfg.domain_high;
        end
        den      = 33'(dhi) - 33'(dlo);
        unum     = (35'(r_x) <<< 1) - 35'(dlo) - 35'(dhi);
        unum_mag = unum[34] ? 34'(-unum) : unum[33:0];
        u_mag    = (div_q[63:0] > 64'h100_0000_0000) ? 41'h100_0000_0000 : div_q[40:0];
        hit      = (r_u == 42'(r_rd_point));
        diff     = 43'(r_u) - 43'(r_rd_point);
        diff_mag = diff[42] ? 43'(-diff) : 43'(diff);
        w_mag    = r_rd_weight[31] ? 32'(-r_rd_weight) : 32'(r_rd_weight);
        v_mag    = r_rd_value[31] ? 32'(-r_rd_value) : 32'(r_rd_value);
        mul_a    = (r_state == bie_pkg::S_MUL_LO) ? r_t[31:0] : {2'b00, r_t[61:32]};
        prod     = 128'(r_p0) + (128'(r_p1) << 32);
        nmag     = r_nsum[127] ? -r_nsum : r_nsum;
        dmag     = r_dsum[127] ? -r_dsum : r_dsum;
        fneg     = r_nsum[127] ^ r_dsum[127];
        fover    = |div_q[127:32];
        fq       = div_q[31:0];
        fsat     = fover || (!fneg && (fq > SAT_POS_C)) || (fneg && (fq > SAT_NEG_C));
    end

    // divider operand selection
    always_comb begin
        unique case (r_state)
            bie_pkg::S_U_START: begin
                div_dvd   = {unum_mag, 30'b0, 64'b0};
                div_dvs   = 128'(unsigned'(den));
                div_steps = bie_pkg::U_STEPS;
            end
            bie_pkg::S_T_START: begin
                div_dvd   = {w_mag, 30'b0, 66'b0};
                div_dvs   = 128'(diff_mag);
                div_steps = bie_pkg::T_STEPS;
            end
            default: begin
                div_dvd   = nmag;
                div_dvs   = dmag;
                div_steps = bie_pkg::FIN_STEPS;
            end
        endcase
    end

    bie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bie_pkg::S_IDLE: begin
                if (i_item_valid && (i_item.kind == bie_pkg::K_EVAL)) begin
                    n_state = bie_pkg::S_U_START;
                end
            end
            bie_pkg::S_U_START: begin
                n_state = (den == 33'sd0) ? bie_pkg::S_RESULT : bie_pkg::S_U_DIV;
            end
            bie_pkg::S_U_DIV: begin
                if (div_done) begin
                    n_state = bie_pkg::S_HIT_RD;
                end
            end
            bie_pkg::S_HIT_RD: begin
                n_state = (r_idx == cnt) ? bie_pkg::S_SUM_RD : bie_pkg::S_HIT_CMP;
            end
            bie_pkg::S_HIT_CMP: begin
                n_state = hit ? bie_pkg::S_RESULT : bie_pkg::S_HIT_RD;
            end
            bie_pkg::S_SUM_RD: begin
                n_state = (r_idx == cnt) ? bie_pkg::S_FIN_START : bie_pkg::S_T_START;
            end
            bie_pkg::S_T_START: n_state = bie_pkg::S_T_DIV;
            bie_pkg::S_T_DIV: begin
                if (div_done) begin
                    n_state = bie_pkg::S_MUL_LO;
                end
            end
            bie_pkg::S_MUL_LO: n_state = bie_pkg::S_MUL_HI;
            bie_pkg::S_MUL_HI: n_state = bie_pkg::S_ACC;
            bie_pkg::S_ACC:    n_state = bie_pkg::S_SUM_RD;
            bie_pkg::S_FIN_START: begin
                n_state = (r_dsum == '0) ? bie_pkg::S_RESULT : bie_pkg::S_FIN_DIV;
            end
            bie_pkg::S_FIN_DIV: begin
                if (div_done) begin
                    n_state = bie_pkg::S_RESULT;
                end
            end
            bie_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = bie_pkg::S_IDLE;
                end
            end
            default: n_state = bie_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            bie_pkg::S_IDLE: begin
                o_pop  = i_item_valid;
                mem_we = i_item_valid && (i_item.kind == bie_pkg::K_LOAD);
            end
            bie_pkg::S_U_START:   div_start = (den != 33'sd0);
            bie_pkg::S_HIT_RD:    rd_en = (r_idx != cnt);
            bie_pkg::S_SUM_RD:    rd_en = (r_idx != cnt);
            bie_pkg::S_T_START:   div_start = 1'b1;
            bie_pkg::S_FIN_START: div_start = (r_dsum != '0);
            bie_pkg::S_RESULT:    out_load = out_free;
            default: ;
        endcase
    end

    // node tables
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_point[wr_ext[AW-1:0]]  <= i_item.node_point;
            r_mem_weight[wr_ext[AW-1:0]] <= i_item.node_weight;
            r_mem_value[wr_ext[AW-1:0]]  <= i_item.node_value;
        end
        if (rd_en) begin
            r_rd_point  <= r_mem_point[r_idx[AW-1:0]];
            r_rd_weight <= r_mem_weight[r_idx[AW-1:0]];
            r_rd_value  <= r_mem_value[r_idx[AW-1:0]];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bie_pkg::S_IDLE: begin
                r_x    <= i_item.query_x;
                r_idx  <= '0;
                r_nsum <= '0;
                r_dsum <= '0;
            end
            bie_pkg::S_U_START: begin
                r_res_value  <= '0;
                r_res_hit    <= 1'b0;
                r_res_status <= 1'b1;
            end
            bie_pkg::S_U_DIV: begin
                r_u <= unum[34] ? -42'(u_mag) : 42'(u_mag);
            end
            bie_pkg::S_HIT_RD: begin
                if (r_idx == cnt) begin
                    r_idx <= '0;
                end
            end
            bie_pkg::S_HIT_CMP: begin
                r_idx        <= r_idx + 1'b1;
                r_res_value  <= r_rd_value;
                r_res_hit    <= 1'b1;
                r_res_status <= 1'b0;
            end
            bie_pkg::S_T_START: begin
                r_tneg <= r_rd_weight[31] ^ diff[42];
            end
            bie_pkg::S_T_DIV:  r_t  <= div_q[61:0];
            bie_pkg::S_MUL_LO: r_p0 <= mul_a * v_mag;
            bie_pkg::S_MUL_HI: r_p1 <= mul_a * v_mag;
            bie_pkg::S_ACC: begin
                r_nsum <= (r_tneg ^ r_rd_value[31]) ? r_nsum - prod : r_nsum + prod;
                r_dsum <= r_tneg ? r_dsum - 128'(r_t) : r_dsum + 128'(r_t);
                r_idx  <= r_idx + 1'b1;
            end
            bie_pkg::S_FIN_START: begin
                r_res_hit    <= 1'b0;
                r_res_status <= 1'b1;
                if (r_nsum[127]) begin
                    r_res_value <= SAT_NEG_C;
                end else if (r_nsum != '0) begin
                    r_res_value <= SAT_POS_C;
                end else begin
                    r_res_value <= '0;
                end
            end
            bie_pkg::S_FIN_DIV: begin
                r_res_status <= fsat;
                if (fsat) begin
                    r_res_value <= fneg ? SAT_NEG_C : SAT_POS_C;
                end else begin
                    r_res_value <= fneg ? -fq : fq;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_value  <= r_res_value;
            r_out_hit    <= r_res_hit;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bie_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_interp_value = r_out_value;
    assign o_exact_hit    = r_out_hit;
    assign o_status       = r_out_status;

endmodule

@@ hdl/barycentric_interpolation_eval_core.sv @@
// Top level: register port, front queue and evaluation back end.
// A load is written to the node tables from the idle state; the front queue holds two beats.
// An evaluate uses the shared serial divider for the scaled query (64 steps),
// for each node's term (62 steps) and for the final quotient (128 steps).
// Synchronous active-low reset clears control state and loads register defaults;
// node tables are not cleared.
module barycentric_interpolation_eval_core #(
    parameter int MAX_NODES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [5:0]         i_node_index,
    input  logic signed [31:0] i_node_point,
    input  logic signed [31:0] i_node_weight,
    input  logic signed [31:0] i_node_value,
    input  logic signed [31:0] i_query_x,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_interp_value,
    output logic               o_exact_hit,
    output logic               o_status
);

    logic signed [31:0] r_domain_low, r_domain_high;
    logic [6:0]         r_node_count;
    logic               wr;
    bie_pkg::t_cfg      cfg;
    bie_pkg::t_item     item;
    logic               item_valid, pop;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain_low  <= bie_pkg::DOMAIN_LOW_RST;
            r_domain_high <= bie_pkg::DOMAIN_HIGH_RST;
            r_node_count  <= bie_pkg::NODE_COUNT_RST;
        end else if (wr) begin
            unique case (paddr[3:2])
                bie_pkg::REG_DOMAIN_LOW:  r_domain_low  <= pwdata;
                bie_pkg::REG_DOMAIN_HIGH: r_domain_high <= pwdata;
                bie_pkg::REG_NODE_COUNT:  r_node_count  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bie_pkg::REG_DOMAIN_LOW:  prdata = r_domain_low;
            bie_pkg::REG_DOMAIN_HIGH: prdata = r_domain_high;
            bie_pkg::REG_NODE_COUNT:  prdata = 32'(r_node_count);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.domain_low  = r_domain_low;
    assign cfg.domain_high = r_domain_high;
    assign cfg.node_count  = r_node_count;

    bie_front #(.MAX_NODES(MAX_NODES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_node_index  (i_node_index),
        .i_node_point  (i_node_point),
        .i_node_weight (i_node_weight),
        .i_node_value  (i_node_value),
        .i_query_x     (i_query_x),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_pop         (pop)
    );

    bie_back #(.MAX_NODES(MAX_NODES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_item_valid   (item_valid),
        .i_item         (item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_interp_value (o_interp_value),
        .o_exact_hit    (o_exact_hit),
        .o_status       (o_status)
    );

endmodule
